[src/fxq_pkg.sv]
// shared types and constants for the q16.16 fixed-point unit
package fxq_pkg;

  // operation codes carried in the mode field
  localparam logic [1:0] MODE_MUL  = 2'd0;
  localparam logic [1:0] MODE_DIV  = 2'd1;
  localparam logic [1:0] MODE_SQRT = 2'd2;
  localparam logic [1:0] MODE_MOD  = 2'd3;

  // special result values and masks
  localparam logic [31:0] DIV_POS_SAT   = 32'h7FFF_FFFF;
  localparam logic [31:0] DIV_NEG_SAT   = 32'h8000_0001;
  localparam logic [31:0] INT_PART_MASK = 32'hFFFF_0000;

  // last step index of each iterative loop, and the step counts of the root and divide loops
  localparam logic [5:0] MUL_LAST  = 6'd31;
  localparam logic [5:0] DIV_LAST  = 6'd47;
  localparam logic [5:0] ROOT_LAST = 6'd15;
  localparam logic [5:0] ROOT_STEPS = 6'd16;
  localparam logic [5:0] DIV_STEPS  = 6'd48;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ABS_A,
    ST_ABS_B,
    ST_MUL,
    ST_DIV,
    ST_ROOT,
    ST_SIGN,
    ST_SQ_ADD,
    ST_MOD_SUB,
    ST_DONE
  } fxq_state_t;

endpackage

[src/fxq_addsub.sv]
// shared 33-bit adder/subtractor with carry out, used by the arithmetic steps of the sequencer
module fxq_addsub
  import fxq_pkg::*;
(
  input  logic [32:0] a,
  input  logic [32:0] b,
  input  logic        sub,
  output logic [32:0] sum,
  output logic        carry
);

  logic [32:0] b_op;

  // subtract as a plus inverted b plus one; carry set means a >= b
  assign b_op = sub ? ~b : b;
  assign {carry, sum} = {1'b0, a} + {1'b0, b_op} + {33'd0, sub};

endmodule

[src/fixed_point_q16_alu_unit.sv]
// top level of the q16.16 fixed-point unit: sequencer, datapath and result register
// operations: multiply, divide, square root and floored modulo; zero-divisor and
//   non-positive root cases skip the loops and go straight to the result
// one item at a time, next beat taken the cycle after the result loads; the
//   48-step divide is the longest loop
// reset: synchronous, returns the sequencer to idle and empties the result register
module fixed_point_q16_alu_unit
  import fxq_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               op_valid,
  output logic               op_stall,
  input  logic [1:0]         mode,
  input  logic signed [31:0] operand_a,
  input  logic signed [31:0] operand_b,
  output logic               res_valid,
  input  logic               res_stall,
  output logic signed [31:0] result
);

  fxq_state_t  state, state_next;
  logic [1:0]  mode_q, mode_q_next;
  logic [31:0] a_q, a_q_next;
  logic [31:0] b_q, b_q_next;
  logic [31:0] opa, opa_next;
  logic        phase, phase_next;
  logic        last_mul, last_mul_next;
  logic        neg, neg_next;
  logic [31:0] x, x_next;
  logic [31:0] y, y_next;
  logic [32:0] hi, hi_next;
  logic [47:0] lo, lo_next;
  logic [5:0]  cnt, cnt_next;
  logic [31:0] fin, fin_next;
  logic        res_valid_next;
  logic [31:0] result_next;

  logic [32:0] add_a, add_b, add_sum;
  logic        add_sub, add_carry;

  logic [32:0] mul_hi;
  logic [32:0] div_rem;
  logic [32:0] root_rem;
  logic [31:0] root_final;
  logic [31:0] sign_val;
  logic [31:0] signed_val;
  logic [31:0] b_mag;

  // the one arithmetic unit shared by the arithmetic steps
  fxq_addsub u_addsub (
    .a     (add_a),
    .b     (add_b),
    .sub   (add_sub),
    .sum   (add_sum),
    .carry (add_carry)
  );

  // per-step helper values
  assign mul_hi     = lo[0] ? add_sum : hi;
  assign div_rem    = {hi[31:0], lo[47]};
  assign root_rem   = {hi[30:0], lo[31:30]};
  assign root_final = {y[30:0], add_carry};
  assign sign_val   = last_mul ? {hi[15:0], lo[31:16]} : lo[31:0];
  assign signed_val = neg ? add_sum[31:0] : sign_val;
  assign b_mag      = b_q[31] ? add_sum[31:0] : b_q;

  assign op_stall = (state != ST_IDLE);

  // sequencer and datapath next values
  always_comb begin
    state_next     = state;
    mode_q_next    = mode_q;
    a_q_next       = a_q;
    b_q_next       = b_q;
    opa_next       = opa;
    phase_next     = phase;
    last_mul_next  = last_mul;
    neg_next       = neg;
    x_next         = x;
    y_next         = y;
    hi_next        = hi;
    lo_next        = lo;
    cnt_next       = cnt;
    fin_next       = fin;
    res_valid_next = res_valid;
    result_next    = result;
    add_a          = '0;
    add_b          = '0;
    add_sub        = 1'b0;

    // result beat taken downstream
    if (res_valid && !res_stall) begin
      res_valid_next = 1'b0;
    end

    unique case (state)
      ST_IDLE: begin
        if (op_valid) begin
          mode_q_next = mode;
          a_q_next    = operand_a;
          b_q_next    = operand_b;
          opa_next    = operand_a;
          phase_next  = 1'b0;
          case (mode)
            MODE_SQRT: begin
              if (operand_a[31] || (operand_a == '0)) begin
                fin_next   = '0;
                state_next = ST_DONE;
              end else begin
                hi_next    = '0;
                lo_next    = {16'd0, operand_a};
                y_next     = '0;
                cnt_next   = '0;
                state_next = ST_ROOT;
              end
            end
            MODE_DIV: begin
              if (operand_b == '0) begin
                fin_next   = operand_a[31] ? DIV_NEG_SAT : DIV_POS_SAT;
                state_next = ST_DONE;
              end else begin
                state_next = ST_ABS_A;
              end
            end
            MODE_MOD: begin
              if (operand_b == '0) begin
                fin_next   = '0;
                state_next = ST_DONE;
              end else begin
                state_next = ST_ABS_A;
              end
            end
            default: begin
              state_next = ST_ABS_A;
            end
          endcase
        end
      end

      // magnitude of the first operand and sign of the outcome
      ST_ABS_A: begin
        add_a      = '0;
        add_b      = {1'b0, opa};
        add_sub    = 1'b1;
        x_next     = opa[31] ? add_sum[31:0] : opa;
        neg_next   = opa[31] ^ b_q[31];
        state_next = ST_ABS_B;
      end

      // magnitude of the second operand, then set up multiply or divide
      ST_ABS_B: begin
        add_a    = '0;
        add_b    = {1'b0, b_q};
        add_sub  = 1'b1;
        y_next   = b_mag;
        hi_next  = '0;
        cnt_next = '0;
        if ((mode_q == MODE_MUL) || phase) begin
          lo_next       = {16'd0, b_mag};
          last_mul_next = 1'b1;
          state_next    = ST_MUL;
        end else begin
          lo_next       = {x, 16'd0};
          last_mul_next = 1'b0;
          state_next    = ST_DIV;
        end
      end

      // shift-add multiply, multiplier bits from the low end
      ST_MUL: begin
        add_a    = {1'b0, hi[31:0]};
        add_b    = {1'b0, x};
        add_sub  = 1'b0;
        hi_next  = {1'b0, mul_hi[32:1]};
        lo_next  = {16'd0, mul_hi[0], lo[31:1]};
        cnt_next = cnt + 6'd1;
        if (cnt == MUL_LAST) begin
          state_next = ST_SIGN;
        end
      end

      // restoring divide of the 48-bit dividend, one quotient bit a step
      ST_DIV: begin
        add_a    = div_rem;
        add_b    = {1'b0, y};
        add_sub  = 1'b1;
        hi_next  = add_carry ? {1'b0, add_sum[31:0]} : div_rem;
        lo_next  = {lo[46:0], add_carry};
        cnt_next = cnt + 6'd1;
        if (cnt == DIV_LAST) begin
          state_next = ST_SIGN;
        end
      end

      // integer root, two radicand bits a step
      ST_ROOT: begin
        add_a   = root_rem;
        add_b   = {y[30:0], 2'b01};
        add_sub = 1'b1;
        if (cnt == ROOT_LAST) begin
          // scale the root by 2^8 and divide the radicand by it
          y_next        = {root_final[23:0], 8'd0};
          hi_next       = '0;
          lo_next       = {a_q, 16'd0};
          neg_next      = 1'b0;
          last_mul_next = 1'b0;
          cnt_next      = '0;
          state_next    = ST_DIV;
        end else begin
          hi_next  = add_carry ? add_sum : root_rem;
          y_next   = root_final;
          lo_next  = {16'd0, lo[29:0], 2'b00};
          cnt_next = cnt + 6'd1;
        end
      end

      // apply the sign and route to the next phase
      ST_SIGN: begin
        add_a    = '0;
        add_b    = {1'b0, sign_val};
        add_sub  = 1'b1;
        fin_next = signed_val;
        case (mode_q)
          MODE_SQRT: begin
            state_next = ST_SQ_ADD;
          end
          MODE_MOD: begin
            if (!phase) begin
              opa_next   = signed_val & INT_PART_MASK;
              phase_next = 1'b1;
              state_next = ST_ABS_A;
            end else begin
              state_next = ST_MOD_SUB;
            end
          end
          default: begin
            state_next = ST_DONE;
          end
        endcase
      end

      // newton step: average of scaled root and quotient
      ST_SQ_ADD: begin
        add_a      = {1'b0, y};
        add_b      = {1'b0, fin};
        add_sub    = 1'b0;
        fin_next   = {1'b0, add_sum[31:1]};
        state_next = ST_DONE;
      end

      // a minus b times the integer quotient
      ST_MOD_SUB: begin
        add_a      = {1'b0, a_q};
        add_b      = {1'b0, fin};
        add_sub    = 1'b1;
        fin_next   = add_sum[31:0];
        state_next = ST_DONE;
      end

      // hand the result to the output register once it is free
      ST_DONE: begin
        if (!res_valid || !res_stall) begin
          res_valid_next = 1'b1;
          result_next    = fin;
          state_next     = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      res_valid <= 1'b0;
      phase     <= 1'b0;
      last_mul  <= 1'b0;
      neg       <= 1'b0;
      cnt       <= '0;
    end else begin
      state     <= state_next;
      res_valid <= res_valid_next;
      phase     <= phase_next;
      last_mul  <= last_mul_next;
      neg       <= neg_next;
      cnt       <= cnt_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    mode_q <= mode_q_next;
    a_q    <= a_q_next;
    b_q    <= b_q_next;
    opa    <= opa_next;
    x      <= x_next;
    y      <= y_next;
    hi     <= hi_next;
    lo     <= lo_next;
    fin    <= fin_next;
    result <= result_next;
  end

  // an accepted beat always starts work
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && op_valid) |=> (state != ST_IDLE))
    else $error("accepted beat did not leave idle");

  // multiply accumulator never carries into the top bit before the add
  a_mul_no_carry: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL) |-> !hi[32])
    else $error("multiply accumulator overflowed");

  // partial remainder stays below a nonzero divisor
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (!hi[32] && (hi[31:0] < y) && (cnt < DIV_STEPS)))
    else $error("divide remainder out of range");

  // root step counter stays below its step count
  a_root_cnt: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROOT) |-> (cnt < ROOT_STEPS))
    else $error("root step counter out of range");

  // finished value lands in the output register
  a_done_load: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && !(res_valid && res_stall)) |=>
      (res_valid && (result == $past(fin)) && (state == ST_IDLE)))
    else $error("result not loaded from finished value");

endmodule
